@@ sv/heightmap_text_point_parser_core_assert.svh @@
// assertion macros shared by the heightmap point parser modules
// expects clk and arst_n in the scope where a macro is used
`ifndef HEIGHTMAP_TEXT_POINT_PARSER_CORE_ASSERT_SVH
`define HEIGHTMAP_TEXT_POINT_PARSER_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define HMTP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define HMTP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/hmtp_pkg.sv @@
// types, constants and helpers for the heightmap text point parser
// no dependencies
package hmtp_pkg;

	localparam int MAX_POINTS = 65536;
	localparam int PCNT_W     = $clog2(MAX_POINTS + 1);

	localparam logic [31:0] COLOR_WHITE = 32'h00FF_FFFF;
	localparam logic [31:0] COLOR_BASE  = 32'h000F_FFFF;
	localparam logic [31:0] COLOR_STEP  = 32'd8352782;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	localparam logic [1:0] CFG_START_X = 2'd0;
	localparam logic [1:0] CFG_START_Y = 2'd1;
	localparam logic [1:0] CFG_SPACING = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_NUM,
		PH_PREFIX,
		PH_HEX,
		PH_TAIL
	} phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} in_beat_t;

	typedef struct packed {
		logic        [15:0] point_index;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [31:0] height;
		logic        [31:0] color;
	} point_t;

	// register values plus write strobes for the coordinate counters
	typedef struct packed {
		logic [15:0] start_x;
		logic [15:0] start_y;
		logic [14:0] spacing;
		logic        load_x;
		logic        load_y;
		logic [15:0] load_val;
	} cfg_t;

	// bit 4 flags a hex digit, bits 3:0 carry its value
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, c[3:0]};
		end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

@@ sv/hmtp_parse.sv @@
// token parser: phase, accumulators, coordinates and point count
// depends on hmtp_pkg and the assertion macro header
`include "heightmap_text_point_parser_core_assert.svh"

module hmtp_parse
	import hmtp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_beat_t beat,
	input  cfg_t     cfg,
	output logic     emit,
	output point_t   point
);

	phase_t              phase_q, nxt_phase;
	logic                neg_q, nxt_neg;
	logic [31:0]         acc_q, nxt_acc;
	logic [31:0]         hex_q, nxt_hex;
	logic                hc_q, nxt_hc;
	logic                pc_q, nxt_pc;
	logic [15:0]         x_q, nxt_x;
	logic [15:0]         y_q, nxt_y;
	logic [PCNT_W-1:0]   cnt_q;

	logic        is_digit, is_minus, is_comma, is_sep, is_nl;
	logic [4:0]  hv;
	logic        take_tok, go_between, late_emit, fire;
	logic        src_neg, src_hc;
	logic [31:0] src_acc, src_hex, z, prod, color;
	logic [15:0] src_x, src_y;

	assign is_digit = beat.ch inside {[8'h30:8'h39]};
	assign is_minus = beat.ch == CH_MINUS;
	assign is_comma = beat.ch == CH_COMMA;
	assign is_nl    = beat.ch == CH_NL;
	assign is_sep   = is_nl || beat.ch == CH_SPACE;
	assign hv       = hex_val(beat.ch);

	always_comb begin
		nxt_phase  = phase_q;
		nxt_neg    = neg_q;
		nxt_acc    = acc_q;
		nxt_hex    = hex_q;
		nxt_hc     = hc_q;
		nxt_pc     = pc_q;
		nxt_x      = x_q;
		nxt_y      = y_q;
		take_tok   = 1'b0;
		go_between = 1'b0;
		case (phase_q)
			PH_NUM: begin
				if (is_digit) begin
					nxt_acc = acc_q * 32'd10 + {28'd0, beat.ch[3:0]};
				end else if (is_comma) begin
					nxt_phase = PH_PREFIX;
					nxt_pc    = 1'b0;
				end else begin
					take_tok   = 1'b1;
					go_between = 1'b1;
				end
			end
			PH_PREFIX: begin
				if (is_sep) begin
					take_tok   = 1'b1;
					go_between = 1'b1;
				end else if (pc_q) begin
					// second prefix char skipped, hex digits follow
					nxt_phase = PH_HEX;
					nxt_hc    = 1'b1;
					nxt_hex   = '0;
					nxt_pc    = 1'b0;
				end else begin
					nxt_pc = 1'b1;
				end
			end
			PH_HEX: begin
				if (hv[4]) begin
					nxt_hex = {hex_q[27:0], hv[3:0]};
				end else if (is_sep) begin
					take_tok   = 1'b1;
					go_between = 1'b1;
				end else begin
					nxt_phase = PH_TAIL;
				end
			end
			PH_TAIL: begin
				if (is_sep) begin
					take_tok   = 1'b1;
					go_between = 1'b1;
				end
			end
			default: begin
				go_between = 1'b1;
			end
		endcase
		if (take_tok) begin
			nxt_phase = PH_IDLE;
			nxt_neg   = 1'b0;
			nxt_acc   = '0;
			nxt_hex   = '0;
			nxt_hc    = 1'b0;
			nxt_pc    = 1'b0;
		end
		if (go_between) begin
			if (is_minus || is_digit) begin
				nxt_x     = x_q + {1'b0, cfg.spacing};
				nxt_phase = PH_NUM;
				nxt_neg   = is_minus;
				nxt_acc   = is_minus ? 32'd0 : {28'd0, beat.ch[3:0]};
				nxt_hex   = '0;
				nxt_hc    = 1'b0;
				nxt_pc    = 1'b0;
			end else if (is_nl) begin
				nxt_x = cfg.start_x;
				nxt_y = y_q + {1'b0, cfg.spacing};
			end
		end
	end

	// an open token at end of text is flushed from the updated state
	assign late_emit = beat.last && !take_tok && nxt_phase != PH_IDLE;
	assign fire      = (take_tok || late_emit) && cnt_q < PCNT_W'(MAX_POINTS);

	assign src_neg = late_emit ? nxt_neg : neg_q;
	assign src_acc = late_emit ? nxt_acc : acc_q;
	assign src_hc  = late_emit ? nxt_hc  : hc_q;
	assign src_hex = late_emit ? nxt_hex : hex_q;
	assign src_x   = late_emit ? nxt_x   : x_q;
	assign src_y   = late_emit ? nxt_y   : y_q;

	assign z    = src_neg ? (32'd0 - src_acc) : src_acc;
	assign prod = z * COLOR_STEP;

	always_comb begin
		if (src_hc) begin
			color = src_hex;
		end else if (z == 32'd0 || z[31]) begin
			color = COLOR_WHITE;
		end else begin
			color = COLOR_BASE + prod;
		end
	end

	assign emit              = step && fire;
	assign point.point_index = cnt_q[15:0];
	assign point.px          = src_x;
	assign point.py          = src_y;
	assign point.height      = z;
	assign point.color       = color;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			hex_q   <= '0;
			hc_q    <= 1'b0;
			pc_q    <= 1'b0;
			x_q     <= '0;
			y_q     <= '0;
			cnt_q   <= '0;
		end else begin
			if (step) begin
				if (beat.last) begin
					phase_q <= PH_IDLE;
					neg_q   <= 1'b0;
					acc_q   <= '0;
					hex_q   <= '0;
					hc_q    <= 1'b0;
					pc_q    <= 1'b0;
					x_q     <= cfg.start_x;
					y_q     <= cfg.start_y;
					cnt_q   <= '0;
				end else begin
					phase_q <= nxt_phase;
					neg_q   <= nxt_neg;
					acc_q   <= nxt_acc;
					hex_q   <= nxt_hex;
					hc_q    <= nxt_hc;
					pc_q    <= nxt_pc;
					x_q     <= nxt_x;
					y_q     <= nxt_y;
					cnt_q   <= cnt_q + PCNT_W'(fire);
				end
			end
			if (cfg.load_x) begin
				x_q <= cfg.load_val;
			end
			if (cfg.load_y) begin
				y_q <= cfg.load_val;
			end
		end
	end

	`HMTP_ASSERT_NXT(a_last_clears, step && beat.last, phase_q == PH_IDLE && cnt_q == '0,
		"end of text did not clear the parser")
	`HMTP_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= PCNT_W'(MAX_POINTS),
		"point count passed its limit")
	`HMTP_ASSERT_NXT(a_cnt_inc, emit && !beat.last, cnt_q == $past(cnt_q) + 1'b1,
		"emitted point not counted")

endmodule

@@ sv/hmtp_out_reg.sv @@
// result register holding one point until the consumer takes it
// depends on hmtp_pkg
module hmtp_out_reg
	import hmtp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load,
	input  point_t load_data,
	input  logic   out_ready,
	output logic   out_valid,
	output point_t out_data,
	output logic   free
);

	logic   vld_q;
	point_t data_q;

	assign free      = !vld_q || out_ready;
	assign out_valid = vld_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (out_ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

@@ sv/heightmap_text_point_parser_core.sv @@
// Heightmap text point parser. Takes one ASCII character per beat and returns one point
// per height token; sustained rate is one character per clock while the consumer keeps
// up. A point reaches out_data through the input register, which takes the beat ending
// its token, and then the result register, loaded as the parse stage updates the token
// state. The single parse stage sets the rate: its token state is updated once per
// character. A stalled consumer holds the stage; one more character still lands in the
// input register.
// Config writes (start_x, start_y, spacing) are taken at once and belong between texts.
// depends on hmtp_pkg, hmtp_parse, hmtp_out_reg and the assertion macro header
`include "heightmap_text_point_parser_core_assert.svh"

module heightmap_text_point_parser_core
	import hmtp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_beat_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output point_t      out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic        vld_s1;
	in_beat_t    beat_s1;
	logic [15:0] start_x_q, start_y_q;
	logic [14:0] spacing_q;
	logic        advance, free, emit, cfg_wr;
	cfg_t        cfg;
	point_t      point;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			spacing_q <= 15'd1;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_START_X: start_x_q <= cfg_data;
				CFG_START_Y: start_y_q <= cfg_data;
				CFG_SPACING: spacing_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	assign cfg.start_x  = start_x_q;
	assign cfg.start_y  = start_y_q;
	assign cfg.spacing  = spacing_q;
	assign cfg.load_x   = cfg_wr && cfg_index == CFG_START_X;
	assign cfg.load_y   = cfg_wr && cfg_index == CFG_START_Y;
	assign cfg.load_val = cfg_data;

	// input register moves on whenever the result slot can take a point
	assign advance  = vld_s1 && free;
	assign in_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s1 <= in_data;
		end
	end

	hmtp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.beat   (beat_s1),
		.cfg    (cfg),
		.emit   (emit),
		.point  (point)
	);

	hmtp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (emit),
		.load_data (point),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.free      (free)
	);

	`HMTP_ASSERT_NXT(a_s1_hold, vld_s1 && !advance, vld_s1 && $stable(beat_s1),
		"held input beat lost or changed")
	`HMTP_ASSERT_NXT(a_emit_shows, emit, out_valid,
		"emitted point not presented")
	`HMTP_ASSERT_IMP(a_emit_needs_step, emit, advance,
		"point emitted without a parse step")

endmodule

@@ test/hmtp_point_checker.sv @@
// point checker for the heightmap text point parser: watches the config, character and
// point channels, predicts every point and compares it field by field
// depends on hmtp_pkg
module hmtp_point_checker
	import hmtp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_beat_t    in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  point_t      out_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] WHITE      = 32'h00FF_FFFF;
	localparam logic [31:0] HEAT_BASE  = 32'h000F_FFFF;
	localparam logic [31:0] HEAT_SLOPE = 32'd8352782;

	logic [15:0] start_x;
	logic [15:0] start_y;
	logic [14:0] spacing;
	phase_t      phase;
	logic        negative;
	logic [31:0] digit_accum;
	logic [31:0] hex_accum;
	logic        has_color;
	int          prefix_count;
	logic [15:0] cur_x;
	logic [15:0] cur_y;
	int          point_count;
	point_t      expected_points[$];
	point_t      want;
	int          fails;

	function automatic logic is_digit(logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic int hex_digit(logic [7:0] c);
		if (is_digit(c)) begin
			return int'(c - "0");
		end
		if ((c >= "a") && (c <= "f")) begin
			return int'(c - "a") + 10;
		end
		if ((c >= "A") && (c <= "F")) begin
			return int'(c - "A") + 10;
		end
		return -1;
	endfunction

	function automatic void clear_token();
		phase        = PH_IDLE;
		negative     = 1'b0;
		digit_accum  = '0;
		hex_accum    = '0;
		has_color    = 1'b0;
		prefix_count = 0;
	endfunction

	// ends the open token; returns whether a point was queued
	function automatic logic close_token();
		logic [31:0] z;
		point_t      p;
		logic        queued;
		queued = 1'b0;
		z = negative ? (32'd0 - digit_accum) : digit_accum;
		p.point_index = point_count[15:0];
		p.px          = cur_x;
		p.py          = cur_y;
		p.height      = z;
		if (has_color) begin
			p.color = hex_accum;
		end else if ((z == 32'd0) || z[31]) begin
			p.color = WHITE;
		end else begin
			p.color = HEAT_BASE + HEAT_SLOPE * z;
		end
		if (point_count < MAX_POINTS) begin
			expected_points.push_back(p);
			point_count++;
			queued = 1'b1;
		end
		clear_token();
		return queued;
	endfunction

	// character seen while no token is open
	function automatic void idle_char(logic [7:0] c);
		if ((c == CH_MINUS) || is_digit(c)) begin
			cur_x = cur_x + {1'b0, spacing};
			clear_token();
			phase = PH_NUM;
			if (c == CH_MINUS) begin
				negative = 1'b1;
			end else begin
				digit_accum = 32'(c - "0");
			end
		end else if (c == CH_NL) begin
			cur_x = start_x;
			cur_y = cur_y + {1'b0, spacing};
		end
	endfunction

	function automatic void parse_char(in_beat_t b);
		logic sent;
		logic sep;
		int   hv;
		sent = 1'b0;
		sep  = (b.ch == CH_SPACE) || (b.ch == CH_NL);
		case (phase)
			PH_NUM: begin
				if (is_digit(b.ch)) begin
					digit_accum = digit_accum * 32'd10 + 32'(b.ch - "0");
				end else if (b.ch == CH_COMMA) begin
					phase        = PH_PREFIX;
					prefix_count = 0;
				end else begin
					sent = close_token();
					idle_char(b.ch);
				end
			end
			PH_PREFIX: begin
				if (sep) begin
					sent = close_token();
					idle_char(b.ch);
				end else begin
					// two non-separator prefix characters are skipped whatever their values
					prefix_count++;
					if (prefix_count >= 2) begin
						phase        = PH_HEX;
						has_color    = 1'b1;
						hex_accum    = '0;
						prefix_count = 0;
					end
				end
			end
			PH_HEX: begin
				hv = hex_digit(b.ch);
				if (hv >= 0) begin
					hex_accum = {hex_accum[27:0], hv[3:0]};
				end else if (sep) begin
					sent = close_token();
					idle_char(b.ch);
				end else begin
					phase = PH_TAIL;
				end
			end
			PH_TAIL: begin
				if (sep) begin
					sent = close_token();
					idle_char(b.ch);
				end
			end
			default: begin
				idle_char(b.ch);
			end
		endcase
		// end of text flushes an open token unless this beat already gave a point
		if (b.last) begin
			if (!sent && (phase != PH_IDLE)) begin
				sent = close_token();
			end
			clear_token();
			cur_x       = start_x;
			cur_y       = start_y;
			point_count = 0;
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] got);
		if (exp_val !== got) begin
			$error("%s mismatch: expected 0x%h, got 0x%h", name, exp_val, got);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x = '0;
			start_y = '0;
			spacing = 15'd1;
			clear_token();
			cur_x       = '0;
			cur_y       = '0;
			point_count = 0;
			expected_points.delete();
			fails = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_START_X: begin
						start_x = cfg_data;
						cur_x   = cfg_data;
					end
					CFG_START_Y: begin
						start_y = cfg_data;
						cur_y   = cfg_data;
					end
					CFG_SPACING: begin
						spacing = cfg_data[14:0];
					end
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready) begin
				parse_char(in_data);
			end
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					$error("point beat with index %0d arrived with none expected",
						out_data.point_index);
					fails++;
				end else begin
					want = expected_points.pop_front();
					check_field("point_index", want.point_index, out_data.point_index);
					check_field("px", want.px, out_data.px);
					check_field("py", want.py, out_data.py);
					check_field("height", want.height, out_data.height);
					check_field("color", want.color, out_data.color);
				end
			end
			fail_count <= fails;
			pending    <= expected_points.size();
		end
	end

endmodule

@@ test/tb_top.sv @@
// top of the heightmap text point parser bench: clock, reset, config writes and text
// stimulus with random gaps on both channels; the point checker judges every point
// depends on hmtp_pkg, hmtp_point_checker and heightmap_text_point_parser_core
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import hmtp_pkg::*;

	localparam logic [1:0] CFG_UNUSED   = 2'd3;
	localparam int         ITEM_TARGET  = 1900;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         DRAIN_CYCLES = 6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_beat_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	point_t      out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int          fail_count;
	int          pending;

	logic        sender_steady = 1'b0;
	logic        receiver_steady = 1'b0;
	logic        hold_off = 1'b0;
	logic [7:0]  text_buf[$];
	int          items_sent = 0;
	string       hex_chars = "0123456789abcdefABCDEF";
	string       junk_chars = "#gqzxX.;!,";

	heightmap_text_point_parser_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	hmtp_point_checker i_point_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	// mostly no gap, some short ones, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(0, 3))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [14:0] pick_spacing();
		case ($urandom_range(0, 4))
			0: return 15'd0;
			1: return 15'h7FFF;
			2, 3: return 15'($urandom_range(1, 4));
			default: return 15'($urandom_range(0, 32767));
		endcase
	endfunction

	function automatic void add_str(string s);
		for (int i = 0; i < s.len(); i++) begin
			text_buf.push_back(s[i]);
		end
	endfunction

	function automatic void add_junk();
		text_buf.push_back(junk_chars[$urandom_range(0, junk_chars.len() - 1)]);
	endfunction

	// one height token, sometimes with a color, sometimes with a broken color prefix
	function automatic void add_token();
		logic neg;
		int   nd;
		int   form;
		neg = ($urandom_range(0, 3) == 0);
		nd  = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
		if (!neg && (nd == 0)) begin
			nd = 1;
		end
		if (neg) begin
			text_buf.push_back(CH_MINUS);
		end
		repeat (nd) text_buf.push_back(hex_chars[$urandom_range(0, 9)]);
		if ($urandom_range(0, 2) == 0) begin
			text_buf.push_back(CH_COMMA);
			form = $urandom_range(0, 9);
			if (form == 0) begin
				return;
			end
			if (form == 1) begin
				text_buf.push_back(hex_chars[$urandom_range(0, 21)]);
				return;
			end
			if (form == 2) begin
				add_junk();
				add_junk();
			end else begin
				add_str("0x");
			end
			repeat ($urandom_range(0, 8)) text_buf.push_back(hex_chars[$urandom_range(0, 21)]);
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 3)) add_junk();
			end
		end
	endfunction

	function automatic void add_separator();
		int r;
		r = $urandom_range(0, 19);
		if (r < 13) begin
			text_buf.push_back(CH_SPACE);
		end else if (r < 16) begin
			text_buf.push_back(CH_NL);
		end else if (r < 18) begin
			add_str("  ");
		end else begin
			text_buf.push_back(CH_SPACE);
			add_junk();
			text_buf.push_back(CH_SPACE);
		end
	endfunction

	task automatic send_beat(input logic [7:0] c, input logic lst);
		int gap;
		gap = sender_steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= {c, lst};
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_text();
		items_sent += text_buf.size();
		for (int i = 0; i < text_buf.size(); i++) begin
			send_beat(text_buf[i], i == text_buf.size() - 1);
		end
		text_buf.delete();
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reconfigure(input int round);
		logic [15:0] sx;
		logic [15:0] sy;
		logic [14:0] sp;
		logic        top_bit;
		if (round == 0) begin
			sx = 16'h8000;
			sy = 16'h8000;
			sp = 15'd0;
		end else if (round == 4) begin
			sx = 16'h7FFF;
			sy = 16'h7FFF;
			sp = 15'h7FFF;
		end else begin
			sx = pick_coord();
			sy = pick_coord();
			sp = pick_spacing();
		end
		top_bit = 1'($urandom_range(0, 1));
		wait_idle();
		write_reg(CFG_START_X, sx);
		write_reg(CFG_START_Y, sy);
		write_reg(CFG_SPACING, {top_bit, sp});
		if ((round == 0) || ($urandom_range(0, 2) == 0)) begin
			write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
		end
	endtask

	// receiver: random stalls, steady stretches, and one long hold-off on request
	initial begin
		int stall;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else if (receiver_steady) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("FAIL heightmap_text_point_parser_core");
		$finish;
	end

	initial begin
		int round;
		int kind;
		int ntok;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone minus with a color and tail, prefix cut by a space, empty color, stray chars
		add_str("-,0xfA#z 4,0 8,0x\n?");
		send_text();
		// wrapping height, then a last beat that ends one token and opens another
		add_str("4294967299 3-");
		send_text();
		add_str("9");
		send_text();

		round = 0;
		while (items_sent < ITEM_TARGET) begin
			if (round % 4 == 0) begin
				reconfigure(round);
			end
			sender_steady   = (round % 7 == 3);
			receiver_steady = sender_steady;
			kind = $urandom_range(0, 9);
			ntok = $urandom_range(1, 30);
			if (round == 5) begin
				// the receiver holds off while texts keep coming, so the block backs up
				sender_steady = 1'b1;
				hold_off      = 1'b1;
				kind          = 0;
				ntok          = 40;
			end
			if (kind == 8) begin
				repeat ($urandom_range(5, 40)) text_buf.push_back(8'($urandom_range(0, 255)));
			end else if (kind == 9) begin
				repeat (ntok) begin
					add_token();
					if ($urandom_range(0, 1) == 0) begin
						text_buf.push_back(8'($urandom_range(0, 255)));
					end else begin
						add_separator();
					end
				end
			end else begin
				repeat (ntok) begin
					add_token();
					add_separator();
				end
				// leave the final token open at the end of text now and then
				if ($urandom_range(0, 2) == 0) begin
					void'(text_buf.pop_back());
				end
			end
			send_text();
			round++;
		end

		// a short text after a spacing change, starting from a fresh count
		wait_idle();
		write_reg(CFG_SPACING, 16'd3);
		sender_steady   = 1'b0;
		receiver_steady = 1'b0;
		add_str("1 -2\n3");
		send_text();

		wait_idle();
		repeat (10) @(posedge clk);
		if ((fail_count == 0) && (pending == 0)) begin
			$display("PASS heightmap_text_point_parser_core");
		end else begin
			$display("FAIL heightmap_text_point_parser_core");
		end
		$finish;
	end

endmodule
